// File: rtl/core/nccc_pkg.sv
`timescale 1ns / 1ps

package nccc_pkg;

    // Configuration register layout.
    localparam int CFG_W       = 36;
    localparam int ORDER_W     = 18;
    localparam int CENTRE_REGS = 6;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CLASS_ORDER = 3'd6;
    localparam logic [ORDER_W-1:0]   ORDER_RESET     = 18'd83525;

    // Slots, classes and counter coordinates are carried in three bits.
    localparam int MAX_SLOTS = 8;
    localparam int SLOT_W    = 3;
    // Width of row * classes + column before it is cut to the memory address.
    localparam int PROD_W    = 6;

    typedef enum logic [1:0] {
        OP_CLASSIFY = 2'd0,
        OP_READ     = 2'd1,
        OP_CLEAR    = 2'd2
    } op_t;

    // Request fields that ride along with the distance pipeline.
    typedef struct packed {
        op_t               op;
        logic [SLOT_W-1:0] true_class;
        logic [SLOT_W-1:0] read_row;
        logic [SLOT_W-1:0] read_col;
    } sideband_t;

endpackage

// File: rtl/core/nccc_argmin.sv
`timescale 1ns / 1ps

// Squared-distance and nearest-slot pipeline. Six register stages: input,
// squares, sums, then a three-level registered tournament. On equal
// distances the higher slot wins, which matches a last-visited-wins scan.
module nccc_argmin #(
    parameter int NUM_CLASSES = 6,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  nccc_pkg::sideband_t                  in_sb,
    input  logic [SAMPLE_BITS-1:0]               in_x,
    input  logic [SAMPLE_BITS-1:0]               in_y,
    input  logic [SAMPLE_BITS-1:0]               in_z,
    input  logic [nccc_pkg::CFG_W-1:0]           centre [nccc_pkg::CENTRE_REGS],
    input  logic [nccc_pkg::ORDER_W-1:0]         class_order,
    output logic                                 out_valid,
    input  logic                                 out_take,
    output nccc_pkg::sideband_t                  out_sb,
    output logic [nccc_pkg::SLOT_W-1:0]          out_winner
);

    localparam int SQW    = 2 * SAMPLE_BITS;
    localparam int DW     = SQW + 2;
    localparam int CEXT   = (3 * SAMPLE_BITS > nccc_pkg::CFG_W) ? 3 * SAMPLE_BITS
                                                                : nccc_pkg::CFG_W;
    localparam int STAGES = 6;

    typedef struct packed {
        logic                          ok;
        logic [nccc_pkg::SLOT_W-1:0]   idx;
        logic [DW-1:0]                 sqd;
    } node_t;

    function automatic logic [SQW-1:0] absq(input logic [SAMPLE_BITS-1:0] a,
                                            input logic [SAMPLE_BITS-1:0] b);
        logic [SAMPLE_BITS-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return SQW'(d) * SQW'(d);
    endfunction

    function automatic node_t pick(input node_t a, input node_t b);
        return (b.ok && (!a.ok || (b.sqd <= a.sqd))) ? b : a;
    endfunction

    logic [STAGES-1:0]         v_reg;
    logic [STAGES-1:0]         en;
    nccc_pkg::sideband_t       sb_reg [STAGES];

    logic [SAMPLE_BITS-1:0]    x_reg;
    logic [SAMPLE_BITS-1:0]    y_reg;
    logic [SAMPLE_BITS-1:0]    z_reg;
    logic [SQW-1:0]            sq_next [nccc_pkg::MAX_SLOTS][3];
    logic [SQW-1:0]            sq_reg  [nccc_pkg::MAX_SLOTS][3];
    node_t                     leaf_reg [nccc_pkg::MAX_SLOTS];
    node_t                     l1_reg [4];
    node_t                     l2_reg [2];
    node_t                     top_node;
    logic [nccc_pkg::SLOT_W-1:0] win_reg;

    logic [3*nccc_pkg::MAX_SLOTS-1:0] order_all;

    // Slots above the six configured ones visit their own centre index.
    assign order_all = {3'd7, 3'd6, class_order};

    always_comb
    begin
        en[STAGES-1] = !v_reg[STAGES-1] || out_take;
        for (int s = STAGES - 2; s >= 0; s--)
        begin
            en[s] = !v_reg[s] || en[s+1];
        end
    end

    assign in_ready   = en[0];
    assign out_valid  = v_reg[STAGES-1];
    assign out_sb     = sb_reg[STAGES-1];
    assign out_winner = win_reg;
    assign top_node   = pick(l2_reg[0], l2_reg[1]);

    always_comb
    begin
        logic [nccc_pkg::SLOT_W-1:0] idx;
        logic [CEXT-1:0]             c;
        for (int i = 0; i < nccc_pkg::MAX_SLOTS; i++)
        begin
            idx = order_all[3*i +: 3];
            c   = '0;
            if (int'(idx) < NUM_CLASSES && int'(idx) < nccc_pkg::CENTRE_REGS)
            begin
                c = CEXT'(centre[idx]);
            end
            sq_next[i][0] = absq(x_reg, c[0 +: SAMPLE_BITS]);
            sq_next[i][1] = absq(y_reg, c[SAMPLE_BITS +: SAMPLE_BITS]);
            sq_next[i][2] = absq(z_reg, c[2*SAMPLE_BITS +: SAMPLE_BITS]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int s = 1; s < STAGES; s++)
            begin
                if (en[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sb_reg[0] <= in_sb;
            x_reg     <= in_x;
            y_reg     <= in_y;
            z_reg     <= in_z;
        end
        for (int s = 1; s < STAGES; s++)
        begin
            if (en[s])
            begin
                sb_reg[s] <= sb_reg[s-1];
            end
        end
        if (en[1])
        begin
            sq_reg <= sq_next;
        end
        if (en[2])
        begin
            for (int i = 0; i < nccc_pkg::MAX_SLOTS; i++)
            begin
                leaf_reg[i].ok  <= (i < NUM_CLASSES);
                leaf_reg[i].idx <= nccc_pkg::SLOT_W'(i);
                leaf_reg[i].sqd <= DW'(sq_reg[i][0]) + DW'(sq_reg[i][1])
                                 + DW'(sq_reg[i][2]);
            end
        end
        if (en[3])
        begin
            for (int j = 0; j < 4; j++)
            begin
                l1_reg[j] <= pick(leaf_reg[2*j], leaf_reg[2*j+1]);
            end
        end
        if (en[4])
        begin
            for (int k = 0; k < 2; k++)
            begin
                l2_reg[k] <= pick(l1_reg[2*k], l1_reg[2*k+1]);
            end
        end
        if (en[5])
        begin
            win_reg <= top_node.idx;
        end
    end

endmodule

// File: rtl/core/nearest_centroid_confusion_counter_unit.sv
// Throughput: one request per cycle unless the result channel stalls; the counter
// memory is read when a request enters the update stage and written when it leaves it,
// and a bump right behind another to the same counter is forwarded.
// Reset (rst_n, asynchronous, active low) sets the centres to zero, the visiting
// order to {5,0,1,3,4,2} and all counters to zero at once; no clearing pass.
`timescale 1ns / 1ps

module nearest_centroid_confusion_counter_unit #(
    parameter int NUM_CLASSES = 6,
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [nccc_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [nccc_pkg::CFG_W-1:0]        cfg_wdata,
    // Request channel.
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        op,
    input  logic [2:0]                        true_class,
    input  logic [SAMPLE_BITS-1:0]            sample_x,
    input  logic [SAMPLE_BITS-1:0]            sample_y,
    input  logic [SAMPLE_BITS-1:0]            sample_z,
    input  logic [2:0]                        read_row,
    input  logic [2:0]                        read_col,
    // Result channel.
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [2:0]                        winner,
    output logic [COUNT_BITS-1:0]             count,
    output logic                              saturated
);

    localparam int DEPTH = NUM_CLASSES * NUM_CLASSES;
    localparam int AW    = $clog2(DEPTH);

    // Configuration registers. The user must change them only while the unit is idle (the
    // block does not enforce this), so the distance pipeline reads them directly.
    logic [nccc_pkg::CFG_W-1:0]   centre_reg [nccc_pkg::CENTRE_REGS];
    logic [nccc_pkg::ORDER_W-1:0] order_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < nccc_pkg::CENTRE_REGS; i++)
            begin
                centre_reg[i] <= '0;
            end
            order_reg <= nccc_pkg::ORDER_RESET;
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < nccc_pkg::CENTRE_REGS; i++)
            begin
                if (cfg_addr == nccc_pkg::CFG_IDX_W'(i))
                begin
                    centre_reg[i] <= cfg_wdata;
                end
            end
            if (cfg_addr == nccc_pkg::REG_CLASS_ORDER)
            begin
                order_reg <= cfg_wdata[nccc_pkg::ORDER_W-1:0];
            end
        end
    end

    // Front end: distances to every slot and the nearest slot.
    logic                          a_ready;
    logic                          a_valid;
    logic                          a_take;
    nccc_pkg::sideband_t           a_sb;
    nccc_pkg::sideband_t           in_sb;
    logic [nccc_pkg::SLOT_W-1:0]   a_winner;

    assign in_sb.op         = nccc_pkg::op_t'(op);
    assign in_sb.true_class = true_class;
    assign in_sb.read_row   = read_row;
    assign in_sb.read_col   = read_col;
    assign in_stall         = !a_ready;

    nccc_argmin #(
        .NUM_CLASSES (NUM_CLASSES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_argmin (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (a_ready),
        .in_sb       (in_sb),
        .in_x        (sample_x),
        .in_y        (sample_y),
        .in_z        (sample_z),
        .centre      (centre_reg),
        .class_order (order_reg),
        .out_valid   (a_valid),
        .out_take    (a_take),
        .out_sb      (a_sb),
        .out_winner  (a_winner)
    );

    // Counter address of the request leaving the front end. A classify request
    // addresses [true_class][winner], a read addresses [read_row][read_col].
    localparam int PROD_W_L = nccc_pkg::PROD_W;

    logic [2:0]        row;
    logic [2:0]        col;
    logic              rd_in_range;
    logic [PROD_W_L-1:0] rd_full;
    logic [AW-1:0]     rd_addr;

    always_comb
    begin
        if (a_sb.op == nccc_pkg::OP_READ)
        begin
            row = a_sb.read_row;
            col = a_sb.read_col;
        end
        else
        begin
            row = a_sb.true_class;
            col = a_winner;
        end
        rd_in_range = (int'(row) < NUM_CLASSES) && (int'(col) < NUM_CLASSES);
        rd_full     = PROD_W_L'(row) * PROD_W_L'(NUM_CLASSES) + PROD_W_L'(col);
        rd_addr     = rd_in_range ? rd_full[AW-1:0] : '0;
    end

    // Counter memory with one read and one write port. Entries whose valid bit
    // is clear read as zero; reset and the clear request drop all valid bits.
    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic [DEPTH-1:0]      vld_reg;

    // Update stage: holds the request while its counter value is read.
    logic                  w_valid_reg;
    nccc_pkg::op_t         w_op_reg;
    logic                  w_in_range_reg;
    logic [AW-1:0]         w_addr_reg;
    logic [2:0]            w_winner_reg;
    logic [COUNT_BITS-1:0] rdata_reg;
    logic                  vbit_reg;

    // Last side effect on the memory, for the request that read in the same
    // cycle as that side effect was written.
    logic                  fw_wr_reg;
    logic                  fw_clr_reg;
    logic [AW-1:0]         fw_addr_reg;
    logic [COUNT_BITS-1:0] fw_data_reg;

    logic                  out_valid_reg;
    logic [2:0]            winner_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  saturated_reg;

    logic                  w_leave;
    logic                  w_load;
    logic [COUNT_BITS-1:0] cur;
    logic                  at_max;
    logic [COUNT_BITS-1:0] bumped;
    logic                  do_write;
    logic                  do_clear;
    logic [2:0]            winner_next;
    logic [COUNT_BITS-1:0] count_next;
    logic                  saturated_next;

    assign w_leave = w_valid_reg && (!out_valid_reg || !out_stall);
    assign w_load  = !w_valid_reg || w_leave;
    assign a_take  = a_valid && w_load;

    always_comb
    begin
        if (fw_clr_reg)
        begin
            cur = '0;
        end
        else if (fw_wr_reg && (fw_addr_reg == w_addr_reg))
        begin
            cur = fw_data_reg;
        end
        else
        begin
            cur = vbit_reg ? rdata_reg : '0;
        end
        at_max   = &cur;
        bumped   = at_max ? cur : cur + COUNT_BITS'(1);
        do_write = w_leave && (w_op_reg == nccc_pkg::OP_CLASSIFY) && w_in_range_reg;
        do_clear = w_leave && (w_op_reg == nccc_pkg::OP_CLEAR);

        winner_next    = '0;
        count_next     = '0;
        saturated_next = 1'b0;
        case (w_op_reg)
            nccc_pkg::OP_CLASSIFY:
            begin
                winner_next = w_winner_reg;
                if (w_in_range_reg)
                begin
                    count_next     = bumped;
                    saturated_next = at_max;
                end
            end
            nccc_pkg::OP_READ:
            begin
                if (w_in_range_reg)
                begin
                    count_next = cur;
                end
            end
            default:
            begin
                count_next = '0;
            end
        endcase
    end

    // Memory array: read when a request enters the update stage, written when a
    // classify request leaves it.
    always_ff @(posedge clk)
    begin
        if (a_take)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (do_write)
        begin
            mem[w_addr_reg] <= bumped;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_take)
        begin
            w_op_reg       <= a_sb.op;
            w_in_range_reg <= rd_in_range;
            w_addr_reg     <= rd_addr;
            w_winner_reg   <= a_winner;
            vbit_reg       <= vld_reg[rd_addr];
        end
        if (w_leave)
        begin
            fw_addr_reg   <= w_addr_reg;
            fw_data_reg   <= bumped;
            winner_reg    <= winner_next;
            count_reg     <= count_next;
            saturated_reg <= saturated_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            w_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            fw_wr_reg     <= 1'b0;
            fw_clr_reg    <= 1'b0;
        end
        else
        begin
            if (w_load)
            begin
                w_valid_reg <= a_valid;
            end
            if (w_leave)
            begin
                out_valid_reg <= 1'b1;
                fw_wr_reg     <= do_write;
                fw_clr_reg    <= do_clear;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (do_clear)
            begin
                vld_reg <= '0;
            end
            else if (do_write)
            begin
                vld_reg[w_addr_reg] <= 1'b1;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign winner    = winner_reg;
    assign count     = count_reg;
    assign saturated = saturated_reg;

endmodule

// File: rtl/core/nccc_checker.sv
`timescale 1ns / 1ps

module nccc_checker #(
    parameter int NUM_CLASSES = 6,
    parameter int COUNT_BITS  = 16
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [2:0]            winner,
    input logic [COUNT_BITS-1:0] count,
    input logic                  saturated
);

    // A stalled result holds until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(winner) && $stable(count)
                                   && $stable(saturated))
        else $error("result changed while stalled");

    // No result is pending right after reset is released.
    a_reset: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("result valid after reset");

    // A held counter is reported at its maximum value.
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> (&count))
        else $error("saturated result below maximum count");

    // The reported slot is always a real slot.
    a_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(winner) < NUM_CLASSES))
        else $error("winner slot out of range");

endmodule

bind nearest_centroid_confusion_counter_unit nccc_checker #(
    .NUM_CLASSES (NUM_CLASSES),
    .COUNT_BITS  (COUNT_BITS)
) u_nccc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .winner    (winner),
    .count     (count),
    .saturated (saturated)
);
